>>> hw/rtl/newton_square_root_top_macros.svh
// Assertion macros for the Newton square root block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef NEWTON_SQUARE_ROOT_TOP_MACROS_SVH
`define NEWTON_SQUARE_ROOT_TOP_MACROS_SVH

// same-cycle implication
`define NSR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nsr: same-cycle implication violated");

// next-cycle implication
`define NSR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nsr: next-cycle implication violated");

`endif

>>> hw/rtl/nsr_pkg.sv
// Shared types and constants of the Newton square root block.
// No dependencies; used by every other file except nsr_stream_if and the macro header.
`default_nettype none

package nsr_pkg;

  localparam int MAX_ITERATIONS = 32;
  localparam int FRAC_BITS      = 16;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 6;
  localparam int ADDR_W = 3;

  localparam logic [DATA_W-1:0] TOL_RESET = 32'd655;

  // register index (paddr word select)
  localparam logic REG_TOLERANCE = 1'b0;

  typedef struct packed {
    logic [DATA_W-1:0] root_operand;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  iteration_index;
    logic [DATA_W-1:0] estimate;
    logic              converged;
    logic              last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic square;
    logic diff;
    logic absval;
    logic check;
    logic emit;
    logic div_start;
    logic update;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
    logic out_free;
    logic div_busy;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/nsr_stream_if.sv
// Valid/ready stream interface used for the request and result channels.
// Payload type is a parameter, taken from nsr_pkg by the instantiating code.
`default_nettype none

interface nsr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/nsr_apb_regs.sv
// APB-style configuration register file: holds the tolerance register.
// Depends on nsr_pkg.
`default_nettype none

module nsr_apb_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [nsr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [nsr_pkg::DATA_W-1:0]   pwdata,
  output logic      [nsr_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic      [nsr_pkg::DATA_W-1:0]   tolerance_o
);

  logic [nsr_pkg::DATA_W-1:0] tolerance_q;
  logic [nsr_pkg::DATA_W-1:0] tolerance_d;
  logic                       sel_tol;
  logic                       wr_en;

  assign pready  = 1'b1;
  assign sel_tol = (paddr[2] == nsr_pkg::REG_TOLERANCE);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    tolerance_d = tolerance_q;
    if (wr_en && sel_tol) begin
      tolerance_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q <= nsr_pkg::TOL_RESET;
    end else begin
      tolerance_q <= tolerance_d;
    end
  end

  assign prdata      = sel_tol ? tolerance_q : '0;
  assign tolerance_o = tolerance_q;

endmodule

`default_nettype wire

>>> hw/rtl/nsr_divider.sv
// Radix-4 restoring divider: two quotient bits per cycle.
// Quotient must fit in 2*QSTEPS bits and remainder in 33 bits. Depends on nsr_pkg.
`default_nettype none

module nsr_divider #(
  parameter int QSTEPS = (32 + nsr_pkg::FRAC_BITS + 1) / 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [63:0]           dividend_i,
  input  wire logic [32:0]           divisor_i,
  output logic                       busy_o,
  output logic      [2*QSTEPS-1:0]   quotient_o
);

  localparam int QW = 2 * QSTEPS;
  localparam int CW = $clog2(QSTEPS + 1);

  logic [32:0]   rem_q;
  logic [32:0]   rem_d;
  logic [32:0]   div_q;
  logic [QW-1:0] dl_q;
  logic [QW-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;

  logic [33:0] t1;
  logic [33:0] t1r;
  logic [33:0] t2;
  logic [33:0] t2r;
  logic        ge1;
  logic        ge2;

  always_comb begin
    t1  = {rem_q, dl_q[QW-1]};
    ge1 = (t1 >= {1'b0, div_q});
    t1r = ge1 ? (t1 - {1'b0, div_q}) : t1;
    t2  = {t1r[32:0], dl_q[QW-2]};
    ge2 = (t2 >= {1'b0, div_q});
    t2r = ge2 ? (t2 - {1'b0, div_q}) : t2;
    rem_d = t2r[32:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(QSTEPS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // top dividend bits are below the divisor since the quotient fits QW bits
      rem_q <= 33'(dividend_i[63:QW]);
      dl_q  <= dividend_i[QW-1:0];
      div_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dl_q  <= {dl_q[QW-3:0], 2'b00};
      quo_q <= {quo_q[QW-3:0], ge1, ge2};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> hw/rtl/nsr_datapath.sv
// Datapath: estimate, square, error magnitude, tolerance test, divider, output register.
// Depends on nsr_pkg and nsr_divider.
`default_nettype none

module nsr_datapath #(
  parameter int MAX_ITERATIONS = nsr_pkg::MAX_ITERATIONS,
  parameter int FRAC_BITS      = nsr_pkg::FRAC_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [nsr_pkg::DATA_W-1:0]  operand_i,
  input  wire logic [nsr_pkg::DATA_W-1:0]  tolerance_i,
  input  wire nsr_pkg::cmd_t               cmd_i,
  output nsr_pkg::status_t                 status_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output nsr_pkg::out_t                    out_payload_o
);

  localparam int QSTEPS = (32 + FRAC_BITS + 1) / 2;
  localparam int QW     = 2 * QSTEPS;
  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  logic [31:0] v_q;
  logic [31:0] x_q;
  logic [31:0] x_d;
  logic [5:0]  i_q;
  logic [63:0] sq_q;
  logic [64:0] diff_q;
  logic [63:0] mag_q;
  logic        above_q;
  logic        met_q;
  logic        limit_q;

  logic        out_valid_q;
  nsr_pkg::out_t out_q;

  logic [63:0] vs;
  logic [63:0] tol;
  logic [QW-1:0] delta;
  logic        div_busy;
  logic [32:0] sum;

  assign vs  = 64'(v_q) << FRAC_BITS;
  assign tol = 64'(tolerance_i) << FRAC_BITS;

  nsr_divider #(
    .QSTEPS(QSTEPS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(mag_q),
    .divisor_i ({x_q, 1'b0}),
    .busy_o    (div_busy),
    .quotient_o(delta)
  );

  // next estimate from the correction
  always_comb begin
    sum = {1'b0, x_q} + {1'b0, delta[31:0]};
    if (above_q) begin
      x_d = (delta >= QW'(x_q)) ? 32'd1 : (x_q - delta[31:0]);
    end else if ((|delta[QW-1:32]) || sum[32]) begin
      x_d = 32'hFFFF_FFFF;
    end else begin
      x_d = sum[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q <= operand_i;
      x_q <= (operand_i > ONE) ? operand_i : ONE;
      i_q <= '0;
    end
    if (cmd_i.square) begin
      sq_q <= 64'(x_q) * 64'(x_q);
    end
    if (cmd_i.diff) begin
      diff_q <= {1'b0, sq_q} - {1'b0, vs};
    end
    if (cmd_i.absval) begin
      above_q <= !diff_q[64];
      mag_q   <= diff_q[64] ? (~diff_q[63:0] + 64'd1) : diff_q[63:0];
    end
    if (cmd_i.check) begin
      met_q   <= (mag_q <= tol);
      limit_q <= (i_q >= 6'(MAX_ITERATIONS));
    end
    if (cmd_i.update) begin
      x_q <= x_d;
      i_q <= i_q + 6'd1;
    end
    if (cmd_i.emit) begin
      out_q.iteration_index <= i_q;
      out_q.estimate        <= x_q;
      out_q.converged       <= met_q;
      out_q.last            <= met_q || limit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_q;

  assign status_o.last     = met_q || limit_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.div_busy = div_busy;

endmodule

`default_nettype wire

>>> hw/rtl/nsr_ctrl.sv
// Controller FSM: sequences load, square, error test, result, divide and update.
// Depends on nsr_pkg.
`default_nettype none

module nsr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire nsr_pkg::status_t  status_i,
  output nsr_pkg::cmd_t          cmd_o
);

  typedef enum logic [3:0] {
    IDLE,
    SQUARE,
    DIFF,
    ABSVAL,
    CHECK,
    WAIT_OUT,
    EMIT,
    DIV_START,
    DIV_WAIT,
    UPDATE
  } state_e;

  state_e        state_q;
  logic          ready_q;
  nsr_pkg::cmd_t cmd_q;

  // the command of a state is registered on entry, so it runs while in that state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      ready_q <= 1'b1;
      cmd_q   <= '0;
    end else begin
      cmd_q <= '0;
      case (state_q)
        IDLE: begin
          if (in_valid_i && ready_q) begin
            state_q      <= SQUARE;
            ready_q      <= 1'b0;
            cmd_q.square <= 1'b1;
          end
        end
        SQUARE: begin
          state_q    <= DIFF;
          cmd_q.diff <= 1'b1;
        end
        DIFF: begin
          state_q      <= ABSVAL;
          cmd_q.absval <= 1'b1;
        end
        ABSVAL: begin
          state_q     <= CHECK;
          cmd_q.check <= 1'b1;
        end
        CHECK: begin
          state_q <= WAIT_OUT;
        end
        WAIT_OUT: begin
          // once free, the slot stays free until we load it
          if (status_i.out_free) begin
            state_q    <= EMIT;
            cmd_q.emit <= 1'b1;
          end
        end
        EMIT: begin
          if (status_i.last) begin
            state_q <= IDLE;
            ready_q <= 1'b1;
          end else begin
            state_q         <= DIV_START;
            cmd_q.div_start <= 1'b1;
          end
        end
        DIV_START: begin
          state_q <= DIV_WAIT;
        end
        DIV_WAIT: begin
          if (!status_i.div_busy) begin
            state_q      <= UPDATE;
            cmd_q.update <= 1'b1;
          end
        end
        UPDATE: begin
          state_q      <= SQUARE;
          cmd_q.square <= 1'b1;
        end
        default: begin
          state_q <= IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  // the operand is captured at the accepting edge, while the payload is still valid
  always_comb begin
    cmd_o      = cmd_q;
    cmd_o.load = (state_q == IDLE) && in_valid_i && ready_q;
  end

  assign in_ready_o = ready_q;

endmodule

`default_nettype wire

>>> hw/rtl/newton_square_root_top.sv
// Newton-Raphson square root, unsigned Q16.16 in and out. One operand is taken
// at a time; a result is produced for the start estimate and for every iterate,
// the final one marked last and flagged converged or not. Each further iterate
// passes the radix-4 divider, which produces two quotient bits per cycle, then
// the update, square, error and output steps; a stall on the result channel
// holds the run. Tolerance is written over the APB port at byte address 0 and
// resets to 655.
// Depends on nsr_pkg, nsr_stream_if, nsr_apb_regs, nsr_ctrl, nsr_datapath.
`default_nettype none

module newton_square_root_top #(
  parameter int MAX_ITERATIONS = nsr_pkg::MAX_ITERATIONS,
  parameter int FRAC_BITS      = nsr_pkg::FRAC_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [nsr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [nsr_pkg::DATA_W-1:0]   pwdata,
  output logic      [nsr_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  nsr_stream_if.sink                        in_i,
  nsr_stream_if.source                      out_o
);

  logic [nsr_pkg::DATA_W-1:0] tolerance;
  nsr_pkg::cmd_t              cmd;
  nsr_pkg::status_t           status;
  logic                       in_ready;
  logic                       out_valid;
  nsr_pkg::out_t              out_payload;

  nsr_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .tolerance_o(tolerance)
  );

  nsr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  nsr_datapath #(
    .MAX_ITERATIONS(MAX_ITERATIONS),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .operand_i    (in_i.payload.root_operand),
    .tolerance_i  (tolerance),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_o.ready),
    .out_payload_o(out_payload)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_payload;

endmodule

`default_nettype wire

>>> hw/rtl/nsr_checker.sv
// Port-level checker for newton_square_root_top, attached by bind.
// Depends on nsr_pkg and newton_square_root_top_macros.svh.
`default_nettype none

`include "newton_square_root_top_macros.svh"

module nsr_checker #(
  parameter int MAX_ITERATIONS = nsr_pkg::MAX_ITERATIONS
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_i,
  input wire logic          out_valid_i,
  input wire logic          out_ready_i,
  input wire nsr_pkg::out_t out_payload_i
);

  // a stalled result holds
  `NSR_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_payload_i))

  // one operand at a time: a taken request closes the input
  `NSR_ASSERT_NXT(a_in_closes, in_valid_i && in_ready_i, !in_ready_i)

  // converged only appears on the final result
  `NSR_ASSERT_IMP(a_conv_last, out_valid_i && out_payload_i.converged, out_payload_i.last)

  // iteration index never passes the limit
  `NSR_ASSERT_IMP(a_idx_range, out_valid_i,
                  out_payload_i.iteration_index <= 6'(MAX_ITERATIONS))

endmodule

bind newton_square_root_top nsr_checker #(
  .MAX_ITERATIONS(MAX_ITERATIONS)
) u_nsr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_payload_i(out_o.payload)
);

`default_nettype wire

>>> verif/nsr_root_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the Newton square root block: watches the APB port and both
// stream channels, predicts every estimate of each operand and compares them.
// Depends on nsr_pkg.

module nsr_root_checker
  import nsr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  in_t               req_payload_i,
  input  logic              res_valid_i,
  input  logic              res_ready_i,
  input  out_t              res_payload_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_o
);

  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct {
    logic [DATA_W-1:0] operand;
    out_t              res;
  } root_expect_t;

  root_expect_t      expected_roots[$];
  logic [DATA_W-1:0] tolerance_q = TOL_RESET;
  int unsigned       mismatches = 0;

  assign mismatch_count_o = mismatches;

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // Queues the start estimate and every iterate until tolerance or the limit.
  function automatic void predict_sqrt_sequence(input logic [DATA_W-1:0] operand);
    logic [63:0]       scaled_op;
    logic [63:0]       scaled_tol;
    logic [63:0]       square;
    logic [63:0]       err_mag;
    logic [63:0]       corr;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] x;
    logic [IDX_W-1:0]  step;
    logic              above;
    logic              done;
    root_expect_t      entry;
    scaled_op  = {32'h0, operand} << FRAC_BITS;
    scaled_tol = {32'h0, tolerance_q} << FRAC_BITS;
    x    = (operand > ONE) ? operand : ONE;
    step = '0;
    done = 1'b0;
    while (!done) begin
      square  = {32'h0, x} * {32'h0, x};
      above   = square >= scaled_op;
      err_mag = above ? square - scaled_op : scaled_op - square;
      entry.operand             = operand;
      entry.res.iteration_index = step;
      entry.res.estimate        = x;
      entry.res.converged       = err_mag <= scaled_tol;
      entry.res.last            = entry.res.converged || (step >= MAX_ITERATIONS);
      expected_roots.push_back(entry);
      done = entry.res.last;
      if (!done) begin
        corr = err_mag / {31'h0, x, 1'b0};
        if (above) begin
          x = (corr >= {32'h0, x}) ? DATA_W'(1) : x - corr[DATA_W-1:0];
        end else begin
          // saturate when the upward correction leaves 32 bits
          sum = {1'b0, x} + corr[DATA_W:0];
          x = (corr[63:DATA_W] != '0 || sum[DATA_W]) ? '1 : sum[DATA_W-1:0];
        end
        step = step + 1'b1;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    root_expect_t want;
    if (!rst_ni) begin
      tolerance_q = TOL_RESET;
      expected_roots.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_TOLERANCE) begin
        if (pwrite) begin
          tolerance_q = pwdata;
        end else if (prdata !== tolerance_q) begin
          log_mismatch($sformatf("tolerance read %h, expected %h", prdata, tolerance_q));
        end
      end
      // results first: a result on the edge of a new request belongs to an older one
      if (res_valid_i && res_ready_i) begin
        if (expected_roots.size() == 0) begin
          log_mismatch($sformatf("unexpected result idx %0d est %h conv %b last %b",
                                 res_payload_i.iteration_index, res_payload_i.estimate,
                                 res_payload_i.converged, res_payload_i.last));
        end else begin
          want = expected_roots.pop_front();
          if (res_payload_i.iteration_index !== want.res.iteration_index ||
              res_payload_i.estimate !== want.res.estimate ||
              res_payload_i.converged !== want.res.converged ||
              res_payload_i.last !== want.res.last) begin
            log_mismatch($sformatf(
              "op %h tol %h: got idx %0d est %h conv %b last %b, want idx %0d est %h conv %b last %b",
              want.operand, tolerance_q, res_payload_i.iteration_index,
              res_payload_i.estimate, res_payload_i.converged, res_payload_i.last,
              want.res.iteration_index, want.res.estimate, want.res.converged,
              want.res.last));
          end
        end
      end
      if (req_valid_i && req_ready_i) predict_sqrt_sequence(req_payload_i.root_operand);
      pending_o <= expected_roots.size();
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Top of the Newton square root testbench: clock, reset, operand and result
// traffic, tolerance writes over APB, watchdog and verdict.
// Depends on nsr_pkg, nsr_stream_if, newton_square_root_top, nsr_root_checker.

module testbench;
  import nsr_pkg::*;

  localparam int unsigned PHASES        = 5;
  localparam int unsigned PHASE_ITEMS   = 80;
  localparam int unsigned HOLD_AFTER    = 40;
  localparam int unsigned HOLD_CYCLES   = 3000;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned STALL_LIMIT   = 20000;
  localparam logic [ADDR_W-1:0] TOL_ADDR = {REG_TOLERANCE, 2'b00};

  localparam logic [DATA_W-1:0] DIRECTED_OPERANDS [14] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001,
    32'h0002_0000, 32'h0004_0000, 32'h0090_0000, 32'h7FFF_FFFF, 32'h8000_0000,
    32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFE_0001
  };

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int unsigned       mismatch_count;
  int unsigned       pending;
  int unsigned       send_burst = 0;
  int unsigned       take_burst = 0;
  int unsigned       results_taken = 0;
  int unsigned       quiet_cycles = 0;

  nsr_stream_if #(.payload_t(in_t))  root_req_if ();
  nsr_stream_if #(.payload_t(out_t)) root_res_if ();

  newton_square_root_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (root_req_if),
    .out_o   (root_res_if)
  );

  nsr_root_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .req_valid_i      (root_req_if.valid),
    .req_ready_i      (root_req_if.ready),
    .req_payload_i    (root_req_if.payload),
    .res_valid_i      (root_res_if.valid),
    .res_ready_i      (root_res_if.ready),
    .res_payload_i    (root_res_if.payload),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // mostly short gaps, a few long ones, and occasional runs with none
  function automatic int unsigned idle_gap(inout int unsigned burst_left);
    int unsigned pick;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (pick < 45) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 200);
  endfunction

  function automatic logic [DATA_W-1:0] random_operand();
    logic [DATA_W-1:0] root;
    case ($urandom_range(0, 9))
      0, 1: return $urandom_range(0, 32'h0002_0000);
      2: begin
        // k*k is an exact square in Q16.16, root k/256
        root = $urandom_range(0, 16'hFFFF);
        return root * root;
      end
      3: return 32'h0000_FFE0 + $urandom_range(0, 64);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_root(input logic [DATA_W-1:0] operand);
    int unsigned gap;
    gap = idle_gap(send_burst);
    if (gap != 0) begin
      root_req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    root_req_if.valid   <= 1'b1;
    root_req_if.payload <= '{root_operand: operand};
    do @(posedge clk_i); while (!root_req_if.ready);
  endtask

  // Lets the last estimate come out, then waits out the block's wind-down.
  task automatic wait_for_idle();
    root_req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write_tolerance(input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TOL_ADDR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // read back, checked by the scoreboard
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [DATA_W-1:0] tol;
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    root_req_if.valid   <= 1'b0;
    root_req_if.payload <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_OPERANDS[i]) send_root(DIRECTED_OPERANDS[i]);
    wait_for_idle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       tol = '0;
        1:       tol = '1;
        2:       tol = 32'd1;
        3:       tol = $urandom_range(2, 4096);
        default: tol = $urandom();
      endcase
      apb_write_tolerance(tol);
      repeat (PHASE_ITEMS) send_root(random_operand());
      wait_for_idle();
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side; one long hold-off backs the block up into its request side
  initial begin
    int unsigned gap;
    root_res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = (results_taken == HOLD_AFTER) ? HOLD_CYCLES : idle_gap(take_burst);
      if (gap != 0) begin
        root_res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      root_res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!root_res_if.valid);
      results_taken++;
    end
  end

  always @(posedge clk_i) begin
    if ((root_req_if.valid && root_req_if.ready) ||
        (root_res_if.valid && root_res_if.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
